/* src/dmim_pkg.sv */
// Shared types and constants for the direct mapped interval monitor.
package dmim_pkg;

  localparam int unsigned TableDepth = 256;

  localparam logic [1:0] FUNC_BEGIN = 2'd0;
  localparam logic [1:0] FUNC_END   = 2'd1;
  localparam logic [1:0] FUNC_TOUT  = 2'd2;
  localparam logic [1:0] FUNC_LOST  = 2'd3;

  localparam logic CFG_HOT_THRESHOLD = 1'b0;
  localparam logic CFG_TIMEOUT_LIMIT = 1'b1;

  localparam logic [31:0] HotThresholdReset = 32'd200;
  localparam logic [31:0] TimeoutLimitReset = 32'd2000;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  slot;
    logic [31:0] sample_value;
    logic [63:0] now_us;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic        flag;
    logic [31:0] last_interval;
    logic [31:0] hit_count;
    logic [63:0] hit_time;
    logic [31:0] hot_count;
    logic [63:0] hot_time;
    logic [31:0] lost_count;
    logic [63:0] lost_time;
    logic [31:0] same_value_count;
    logic [31:0] up_sum;
    logic [31:0] down_sum;
  } out_word_t;

  // One stored entry of the table.
  typedef struct packed {
    logic        open;
    logic [63:0] begin_stamp;
    logic [31:0] begin_value;
    logic [31:0] interval;
    logic [31:0] hits;
    logic [63:0] hit_time;
    logic [31:0] hot_count;
    logic [63:0] hot_time;
    logic [31:0] lost_count;
    logic [63:0] lost_time;
    logic [31:0] same_count;
    logic [31:0] up_sum;
    logic [31:0] down_sum;
    logic [31:0] unmatched;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

endpackage

/* src/dmim_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module dmim_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/dmim_update.sv */
// Combinational read-modify-write of one table entry.
module dmim_update (
  input  dmim_pkg::in_word_t  item,
  input  logic                valid_in,
  input  dmim_pkg::entry_t    cur,
  input  logic [31:0]         hot_threshold,
  input  logic [31:0]         timeout_limit,
  output dmim_pkg::entry_t    nxt,
  output logic                valid_out,
  output logic                write_en,
  output dmim_pkg::out_word_t result
);
  dmim_pkg::entry_t base;
  logic [63:0] d;

  always_comb begin
    base = valid_in ? cur : '0;
    d = item.now_us - base.begin_stamp;
    nxt = base;
    valid_out = valid_in;
    write_en = 1'b0;
    result = '0;
    case (item.func)
      dmim_pkg::FUNC_BEGIN: begin
        valid_out = 1'b1;
        write_en = 1'b1;
        if (base.open) begin
          nxt.lost_count = base.lost_count + 32'd1;
          nxt.lost_time = base.lost_time + d;
        end
        nxt.begin_stamp = item.now_us;
        nxt.begin_value = item.sample_value;
        nxt.open = 1'b1;
      end
      dmim_pkg::FUNC_END: begin
        write_en = valid_in;
        if (base.open) begin
          nxt.hits = base.hits + 32'd1;
          nxt.hit_time = base.hit_time + d;
          if (d >= {32'd0, hot_threshold}) begin
            nxt.hot_count = base.hot_count + 32'd1;
            nxt.hot_time = base.hot_time + d;
          end
          nxt.interval = d[31:0];
          nxt.open = 1'b0;
          nxt.begin_stamp = '0;
          if (item.sample_value == base.begin_value) begin
            nxt.same_count = base.same_count + 32'd1;
          end else if (item.sample_value > base.begin_value) begin
            nxt.up_sum = base.up_sum + (item.sample_value - base.begin_value);
          end else begin
            nxt.down_sum = base.down_sum + (base.begin_value - item.sample_value);
          end
        end else begin
          nxt.unmatched = base.unmatched + 32'd1;
        end
      end
      dmim_pkg::FUNC_TOUT: result.flag = valid_in && !base.open &&
                                         (base.interval >= timeout_limit);
      default: result.flag = valid_in && base.open;
    endcase
    if (valid_out) begin
      result.accepted = 1'b1;
      result.last_interval = nxt.interval;
      result.hit_count = nxt.hits;
      result.hit_time = nxt.hit_time;
      result.hot_count = nxt.hot_count;
      result.hot_time = nxt.hot_time;
      result.lost_count = nxt.lost_count;
      result.lost_time = nxt.lost_time;
      result.same_value_count = nxt.same_count;
      result.up_sum = nxt.up_sum;
      result.down_sum = nxt.down_sum;
    end
  end
endmodule

/* src/direct_mapped_interval_monitor.sv */
// Direct mapped interval monitor: table of per-slot interval counters.
// A word accepted into stage 1 reads the entry RAM at the same edge; its
// result word is registered on out_* as stage 1 advances. Throughput: one
// word per cycle while out_ready drains the output; a back-to-back hit on the
// same slot is served by forwarding the just-written entry around the RAM read.
// Reset: valid bits (flip-flops, one per entry) clear at once; registers
// return to 200 and 2000; no clearing pass, invalid entries read as zero.
module direct_mapped_interval_monitor #(
  parameter int unsigned TABLE_DEPTH = dmim_pkg::TableDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dmim_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dmim_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata
);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [31:0] hot_threshold_r, timeout_limit_r;
  logic [TABLE_DEPTH-1:0] valid_r;

  // Stage 1: word whose entry is being read.
  logic               s1_valid_r;
  dmim_pkg::in_word_t s1_item_r;
  logic [AW-1:0]      s1_addr_r;
  // Last write, for forwarding.
  logic               fw_valid_r;
  logic [AW-1:0]      fw_addr_r;
  dmim_pkg::entry_t   fw_entry_r;
  // Output register.
  logic                out_valid_r;
  dmim_pkg::out_word_t out_data_r;

  logic [AW-1:0]       in_addr;
  logic [AW-1:0]       rd_addr;
  logic [dmim_pkg::EntryWidth-1:0] ram_rdata;
  dmim_pkg::entry_t    cur, nxt;
  logic                ent_valid, valid_nxt, we, upd_we;
  dmim_pkg::out_word_t result;
  logic                s1_adv;

  // Slot modulo 2**AW: low bits of the slot, zero-extended where depth exceeds 256.
  assign in_addr = AW'({{(AW > 8 ? AW : 8){1'b0}}, in_data.slot});

  // Stage 1 advances whenever the output register is free or being drained.
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = s1_adv;

  // Hold the read on the stage 1 entry while stalled, so the RAM output
  // keeps tracking that entry and picks up the last write.
  assign rd_addr = s1_adv ? in_addr : s1_addr_r;

  dmim_ram #(.WIDTH(dmim_pkg::EntryWidth), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr_r),
    .wdata (nxt),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Forward the entry written last cycle when the RAM read missed it.
  assign cur = (fw_valid_r && fw_addr_r == s1_addr_r) ? fw_entry_r
                                                      : dmim_pkg::entry_t'(ram_rdata);
  assign ent_valid = valid_r[s1_addr_r];

  dmim_update u_update (
    .item          (s1_item_r),
    .valid_in      (ent_valid),
    .cur           (cur),
    .hot_threshold (hot_threshold_r),
    .timeout_limit (timeout_limit_r),
    .nxt           (nxt),
    .valid_out     (valid_nxt),
    .write_en      (upd_we),
    .result        (result)
  );

  // Write back only when the word retires into the output register.
  assign we = s1_valid_r && s1_adv && upd_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hot_threshold_r <= dmim_pkg::HotThresholdReset;
      timeout_limit_r <= dmim_pkg::TimeoutLimitReset;
      valid_r         <= '0;
      s1_valid_r      <= 1'b0;
      fw_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          dmim_pkg::CFG_HOT_THRESHOLD: hot_threshold_r <= cfg_wdata;
          dmim_pkg::CFG_TIMEOUT_LIMIT: timeout_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (s1_adv) begin
        s1_valid_r  <= in_valid;
        out_valid_r <= s1_valid_r;
      end
      fw_valid_r <= we;
      if (we) begin
        valid_r[s1_addr_r] <= valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_item_r  <= in_data;
      s1_addr_r  <= in_addr;
      out_data_r <= result;
    end
    if (we) begin
      fw_addr_r  <= s1_addr_r;
      fw_entry_r <= nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule
